/* hw/rtl/sfm_pkg.sv */
// Shared types and constants for the substring first-match search block.
`timescale 1ns / 1ps

package sfm_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 32;
  localparam int FUNC_W = 2;

  // Selector codes as they arrive on the func port.
  localparam logic [FUNC_W-1:0] FUNC_NEEDLE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HAYSTACK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

  // Kind of work carried from the front to the engine.
  typedef enum logic [1:0] {
    K_NEEDLE   = 2'd0,
    K_HAYSTACK = 2'd1,
    K_CLEAR    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             needle_too_long;
  } result_t;

endpackage

/* hw/rtl/substring_first_match.sv */
// Top level of the substring first-match search block.
`timescale 1ns / 1ps

// Streams a haystack one byte per clock while the engine is not held and
// reports where a stored needle first occurs. Both sides behave as queues: a
// transaction enters when push is high and full is low, and a result leaves
// when pop is high and empty is low. Load a needle with func = 0 bytes,
// ending with last = 1; it is kept for every following haystack until a new
// needle starts or a func = 2 clear item empties it. Bytes beyond MAX_NEEDLE
// are dropped and reported through needle_too_long. Each haystack is sent as
// func = 1 bytes, and the byte with last = 1 produces exactly one result:
// found, the offset of the first match start in position (zero when nothing
// matched), and the needle overflow flag. An empty needle always matches at
// offset zero. The search engine takes every item, needle or haystack, at
// one transaction per clock while it is not held; the rate is set by the
// window compare, in which all MAX_NEEDLE lanes check the stored needle
// bytes against the window in parallel. A haystack's last byte is written
// to the input queue, handled by the engine while it sits at the head of
// that queue, and its result is written to the result queue, whose head
// drives the output ports. Items with func = 3 are accepted and ignored.
// The engine holds only when the result queue is full and the next item
// would produce a result; the input queue absorbs that stall.
module substring_first_match #(
  parameter int MAX_NEEDLE  = 64,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [sfm_pkg::FUNC_W-1:0]  func,
  input  logic [sfm_pkg::BYTE_W-1:0]  data,
  input  logic                        last,
  output logic                        empty,
  input  logic                        pop,
  output logic                        found,
  output logic [sfm_pkg::POS_W-1:0]   position,
  output logic                        needle_too_long
);

  import sfm_pkg::*;

  // Front to engine: queued work items.
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;

  // Engine to result queue.
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;

  sfm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .func    (func),
    .data    (data),
    .last    (last),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  sfm_back #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_item  (q_item),
    .in_pop   (q_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_res  (res_in)
  );

  // The result queue decouples the engine from a slow consumer.
  sfm_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign found           = res_out.found;
  assign position        = res_out.position;
  assign needle_too_long = res_out.needle_too_long;

endmodule

/* hw/rtl/sfm_fifo.sv */
// Small first-word-fall-through queue built from registers.
`timescale 1ns / 1ps

module sfm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_en;
  logic             rd_en;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |=> count == $past(count) + CW'(1))
    else $error("queue count did not grow on a lone write");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    rd_en && !wr_en |=> count == $past(count) - CW'(1))
    else $error("queue count did not shrink on a lone read");
`endif

endmodule

/* hw/rtl/sfm_front.sv */
// Input side: decodes the selector and queues work items for the engine.
`timescale 1ns / 1ps

module sfm_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [sfm_pkg::FUNC_W-1:0]       func,
  input  logic [sfm_pkg::BYTE_W-1:0]       data,
  input  logic                             last,
  output logic                             q_valid,
  output sfm_pkg::item_t                   q_item,
  input  logic                             q_pop
);

  import sfm_pkg::*;

  item_t item;
  logic  keep;
  logic  q_empty;

  // The unused selector code is swallowed here and never reaches the engine.
  always_comb begin
    item.data = data;
    item.last = last;
    item.kind = K_NEEDLE;
    keep      = 1'b1;
    case (func)
      FUNC_NEEDLE:   item.kind = K_NEEDLE;
      FUNC_HAYSTACK: item.kind = K_HAYSTACK;
      FUNC_CLEAR:    item.kind = K_CLEAR;
      default:       keep = 1'b0;
    endcase
  end

  sfm_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .wdata (item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  assign q_valid = !q_empty;

endmodule

/* hw/rtl/sfm_back.sv */
// Search engine: holds the needle and window and compares every window position.
`timescale 1ns / 1ps

module sfm_back #(
  parameter int MAX_NEEDLE = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sfm_pkg::item_t   in_item,
  output logic             in_pop,
  input  logic             out_full,
  output logic             out_push,
  output sfm_pkg::result_t out_res
);

  import sfm_pkg::*;

  localparam int LW = $clog2(MAX_NEEDLE + 1);

  // The needle is kept newest byte first, so entry i lines up with window
  // entry i whatever the needle length is.
  logic [BYTE_W-1:0] pat [MAX_NEEDLE];
  logic [BYTE_W-1:0] win [MAX_NEEDLE];
  logic [BYTE_W-1:0] win_new [MAX_NEEDLE];
  logic [LW-1:0]     plen;
  logic              povf;
  logic              prestart;
  logic [POS_W-1:0]  seen;
  logic              mseen;
  logic [POS_W-1:0]  moff;

  logic              go;
  logic              is_hay;
  logic              is_needle;
  logic [LW-1:0]     len_base;
  logic              room;
  logic [POS_W-1:0]  seen_next;
  logic [POS_W-1:0]  offset;
  logic [MAX_NEEDLE-1:0] lane_ok;
  logic              window_eq;
  logic              hit;

  assign is_hay    = (in_item.kind == K_HAYSTACK);
  assign is_needle = (in_item.kind == K_NEEDLE);
  assign go        = in_valid && !(is_hay && in_item.last && out_full);
  assign in_pop    = go;
  assign out_push  = go && is_hay && in_item.last;

  assign len_base = prestart ? '0 : plen;
  assign room     = (len_base < LW'(MAX_NEEDLE));

  always_comb begin
    win_new[0] = in_item.data;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      win_new[k] = win[k-1];
    end
  end

  // Lane i checks the needle byte i places from its end against the window
  // byte i places back from the newest one.
  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      if (LW'(i) < plen) begin
        lane_ok[i] = (pat[i] == win_new[i]);
      end else begin
        lane_ok[i] = 1'b1;
      end
    end
  end

  assign window_eq = &lane_ok;
  assign seen_next = (seen == '1) ? seen : seen + POS_W'(1);
  assign offset    = seen_next - POS_W'(plen);
  assign hit       = !mseen && (plen != '0) && (seen_next >= POS_W'(plen)) && window_eq;

  always_comb begin
    out_res.needle_too_long = povf;
    if (plen == '0) begin
      out_res.found    = 1'b1;
      out_res.position = '0;
    end else if (mseen) begin
      out_res.found    = 1'b1;
      out_res.position = moff;
    end else if (hit) begin
      out_res.found    = 1'b1;
      out_res.position = offset;
    end else begin
      out_res.found    = 1'b0;
      out_res.position = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && is_needle && room) begin
      pat[0] <= in_item.data;
      for (int k = 1; k < MAX_NEEDLE; k++) begin
        pat[k] <= pat[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && is_hay) begin
      for (int k = 0; k < MAX_NEEDLE; k++) begin
        win[k] <= win_new[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen     <= '0;
      povf     <= 1'b0;
      prestart <= 1'b1;
      seen     <= '0;
      mseen    <= 1'b0;
      moff     <= '0;
    end else if (go) begin
      case (in_item.kind)
        K_NEEDLE: begin
          if (room) begin
            plen <= len_base + LW'(1);
            povf <= prestart ? 1'b0 : povf;
          end else begin
            plen <= len_base;
            povf <= 1'b1;
          end
          prestart <= in_item.last;
        end
        K_CLEAR: begin
          plen     <= '0;
          povf     <= 1'b0;
          prestart <= 1'b1;
        end
        K_HAYSTACK: begin
          if (in_item.last) begin
            seen  <= '0;
            mseen <= 1'b0;
            moff  <= '0;
          end else begin
            seen <= seen_next;
            if (hit) begin
              mseen <= 1'b1;
              moff  <= offset;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    plen <= LW'(MAX_NEEDLE))
    else $error("needle length above capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    povf |-> plen == LW'(MAX_NEEDLE))
    else $error("overflow flagged on a needle that is not full");

  a_offset_order: assert property (@(posedge clk) disable iff (rst)
    mseen |-> moff < seen)
    else $error("recorded match starts beyond the bytes seen");

  a_clear_effect: assert property (@(posedge clk) disable iff (rst)
    go && in_item.kind == K_CLEAR |=> plen == '0 && !povf && prestart)
    else $error("clear item did not empty the needle");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into a full result queue");
`endif

endmodule
